>>> hw/rtl/tlbfl_pkg.sv
// ----------------------------------------------------------------------------
// tlbfl_pkg
// Shared types and constants for the FIFO/LRU translation buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package tlbfl_pkg;

   localparam int ENTRIES    = 16;
   localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int FILL_W     = $clog2(ENTRIES + 1);
   localparam int LIM_W      = (FILL_W > 5) ? FILL_W : 5;
   localparam int STAMP_W    = 32;
   localparam int PAGE_W     = 32;
   localparam int PID_W      = 16;
   localparam int FRAME_W    = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 5;

   localparam logic [CSR_IDX_W-1:0]  CSR_MODE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0]  CSR_LIMIT   = 2'd1;
   localparam logic [CSR_DATA_W-1:0] LIMIT_RESET = 5'd16;

   localparam logic MODE_FIFO  = 1'b0;
   localparam logic MODE_LRU   = 1'b1;
   localparam logic CMD_LOOKUP = 1'b0;
   localparam logic CMD_INSERT = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FIN
   } state_type;

   // Search packet handed from cell to cell
   typedef struct packed {
      logic               cmd;
      logic [PAGE_W-1:0]  page;
      logic [PID_W-1:0]   owner;
      logic               found;
      logic [IDX_W-1:0]   best_idx;
      logic [STAMP_W-1:0] best_age;
      logic [STAMP_W-1:0] best_use;
      logic [FRAME_W-1:0] best_frame;
      logic               free_found;
      logic [IDX_W-1:0]   free_idx;
   } pkt_type;

   // Broadcast update to one cell
   typedef struct packed {
      logic               en;
      logic               insert;
      logic [IDX_W-1:0]   idx;
      logic [PAGE_W-1:0]  page;
      logic [PID_W-1:0]   owner;
      logic [FRAME_W-1:0] frame;
      logic [STAMP_W-1:0] stamp;
   } wr_type;

endpackage

`default_nettype wire

>>> hw/rtl/tlbfl_cell.sv
// ----------------------------------------------------------------------------
// tlbfl_cell
// One table entry plus its stage of the search chain.
// ----------------------------------------------------------------------------
`default_nettype none

module tlbfl_cell
   import tlbfl_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [IDX_W-1:0]   cell_idx,
   input  wire logic               mode,
   input  wire logic [STAMP_W-1:0] next_stamp,
   input  wire logic               advance,
   input  wire pkt_type            pkt_i,
   output pkt_type                 pkt_o,
   input  wire wr_type             wr,
   output logic                    valid_o
);

   logic               valid_ff;
   logic [PAGE_W-1:0]  page_ff;
   logic [PID_W-1:0]   owner_ff;
   logic [FRAME_W-1:0] frame_ff;
   logic [STAMP_W-1:0] ins_ff;
   logic [STAMP_W-1:0] use_ff;
   pkt_type            pkt_ff;
   pkt_type            pkt_in;

   logic [STAMP_W-1:0] age;
   logic               cand;
   logic               better;
   logic               sel;

   assign sel = wr.en && (wr.idx == cell_idx);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (sel && wr.insert) begin
         valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (sel) begin
         use_ff <= wr.stamp;
         if (wr.insert) begin
            page_ff  <= wr.page;
            owner_ff <= wr.owner;
            frame_ff <= wr.frame;
            ins_ff   <= wr.stamp;
         end
      end
   end

   always_comb begin
      age = next_stamp - ins_ff;
      if (pkt_i.cmd == CMD_LOOKUP) begin
         cand   = valid_ff && (page_ff == pkt_i.page) && (owner_ff == pkt_i.owner);
         better = !pkt_i.found || (age > pkt_i.best_age);
      end else begin
         cand = valid_ff;
         if (mode == MODE_LRU) begin
            better = !pkt_i.found || (use_ff < pkt_i.best_use) ||
                     ((use_ff == pkt_i.best_use) && (age > pkt_i.best_age));
         end else begin
            better = !pkt_i.found || (age > pkt_i.best_age);
         end
      end

      pkt_in = pkt_i;
      if (cand && better) begin
         pkt_in.found      = 1'b1;
         pkt_in.best_idx   = cell_idx;
         pkt_in.best_age   = age;
         pkt_in.best_use   = use_ff;
         pkt_in.best_frame = frame_ff;
      end
      // lowest free slot: first one seen down the chain
      if (!valid_ff && !pkt_i.free_found) begin
         pkt_in.free_found = 1'b1;
         pkt_in.free_idx   = cell_idx;
      end
   end

   // the whole chain freezes while a finished search waits for the output
   always_ff @(posedge clock) begin
      if (advance) begin
         pkt_ff <= pkt_in;
      end
   end

   assign pkt_o   = pkt_ff;
   assign valid_o = valid_ff;

endmodule

`default_nettype wire

>>> hw/rtl/tlb_fifo_lru_replacement.sv
// ----------------------------------------------------------------------------
// tlb_fifo_lru_replacement
// Fully associative translation buffer, FIFO or LRU replacement.
// ----------------------------------------------------------------------------
// Request channel (req_*): command 0 looks up {process_id, page_number},
// command 1 inserts a translation to frame_in. One response per request on
// the rsp_* channel: hit and frame_out for a lookup, zeros for an insert.
// A transfer happens on a rising edge with valid high and stall low.
// Each request walks a chain of ENTRIES cells, one cell per cycle, carrying
// the best match or replacement candidate so far; past the last cell, in
// the finish state, the table is updated and the response registered. One
// request is in flight, so a new one is taken only once the last has left
// the chain. The response register lets the next request be taken while a
// response waits; a stalled response holds its chain result until the
// output register frees up.
// csr_*: index 0 replace mode, index 1 entry limit; writes always accepted.
// Synchronous reset empties the table and restores FIFO mode, limit 16.
// ----------------------------------------------------------------------------
`default_nettype none

module tlb_fifo_lru_replacement
   import tlbfl_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic                  req_command,
   input  wire logic [PAGE_W-1:0]     req_page_number,
   input  wire logic [PID_W-1:0]      req_process_id,
   input  wire logic [FRAME_W-1:0]    req_frame_in,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic                       rsp_hit,
   output logic [FRAME_W-1:0]         rsp_frame_out,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   state_type           state_ff, state_in;
   logic [IDX_W-1:0]    cnt_ff, cnt_in;
   logic                mode_ff;
   logic [CSR_DATA_W-1:0] limit_ff;
   logic [FILL_W-1:0]   fill_ff, fill_in;
   logic [STAMP_W-1:0]  stamp_ff, stamp_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_hit_ff, rsp_hit_in;
   logic [FRAME_W-1:0]  rsp_frame_ff, rsp_frame_in;

   logic                accept;
   logic                load;
   logic                advance;
   pkt_type             launch;
   pkt_type             chain [ENTRIES];
   logic [ENTRIES-1:0]  valid_vec;
   wr_type              wr;
   pkt_type             fin;
   logic [LIM_W-1:0]    lim;
   logic                below_lim;
   logic                use_free;
   logic                touch;

   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign advance   = !((state_ff == ST_FIN) && !load);

   // ---------------------------------------------------------------- csr
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_FIFO;
         limit_ff <= LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MODE:  mode_ff  <= csr_wdata[0];
            CSR_LIMIT: limit_ff <= csr_wdata;
            default:   ;
         endcase
      end
   end

   // ---------------------------------------------------------------- chain
   always_comb begin
      launch            = '0;
      launch.cmd        = req_command;
      launch.page       = req_page_number;
      launch.owner      = req_process_id;
   end

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      pkt_type pkt_src;
      if (i == 0) begin : g_head
         assign pkt_src = launch;
      end else begin : g_link
         assign pkt_src = chain[i-1];
      end
      tlbfl_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_idx   (IDX_W'(i)),
         .mode       (mode_ff),
         .next_stamp (stamp_ff),
         .advance    (advance),
         .pkt_i      (pkt_src),
         .pkt_o      (chain[i]),
         .wr         (wr),
         .valid_o    (valid_vec[i])
      );
   end

   assign fin = chain[ENTRIES-1];

   // frame_in is captured at request transfer; the chain carries command and key
   logic [FRAME_W-1:0] frame_ff;
   always_ff @(posedge clock) begin
      if (accept) begin
         frame_ff <= req_frame_in;
      end
   end

   // ---------------------------------------------------------------- fsm
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (accept) state_in = (ENTRIES == 1) ? ST_FIN : ST_SCAN;
         ST_SCAN: if (cnt_ff == IDX_W'(ENTRIES - 2)) state_in = ST_FIN;
         ST_FIN:  if (load) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      load      = 1'b0;
      case (state_ff)
         ST_IDLE: req_stall = 1'b0;
         ST_SCAN: ;
         ST_FIN:  load = !rsp_valid_ff || !rsp_stall;
         default: ;
      endcase
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (accept) begin
         cnt_in = '0;
      end else if (state_ff == ST_SCAN) begin
         cnt_in = cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // ---------------------------------------------------------------- update
   always_comb begin
      lim = LIM_W'(limit_ff);
      if (lim == '0) begin
         lim = LIM_W'(1);
      end else if (lim > LIM_W'(ENTRIES)) begin
         lim = LIM_W'(ENTRIES);
      end
      below_lim = LIM_W'(fill_ff) < lim;
      use_free  = fin.free_found && (below_lim || !fin.found);
      touch     = fin.found && (mode_ff == MODE_LRU);

      wr        = '0;
      wr.page   = fin.page;
      wr.owner  = fin.owner;
      wr.frame  = frame_ff;
      wr.stamp  = stamp_ff;
      if (fin.cmd == CMD_INSERT) begin
         wr.insert = 1'b1;
         wr.en     = load && (use_free || fin.found);
         wr.idx    = use_free ? fin.free_idx : fin.best_idx;
      end else begin
         wr.en     = load && touch;
         wr.idx    = fin.best_idx;
      end

      fill_in  = fill_ff;
      if (load && (fin.cmd == CMD_INSERT) && use_free) begin
         fill_in = fill_ff + 1'b1;
      end
      stamp_in = wr.en ? stamp_ff + 1'b1 : stamp_ff;

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_hit_in   = rsp_hit_ff;
      rsp_frame_in = rsp_frame_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_hit_in   = (fin.cmd == CMD_LOOKUP) && fin.found;
         rsp_frame_in = rsp_hit_in ? fin.best_frame : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         stamp_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         stamp_ff     <= stamp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_hit_ff   <= rsp_hit_in;
      rsp_frame_ff <= rsp_frame_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_hit       = rsp_hit_ff;
   assign rsp_frame_out = rsp_frame_ff;

`ifndef SYNTH
   a_fill_matches_valid: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == 32'(fill_ff))
      else $error("fill count out of step with valid entries");

   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      32'(fill_ff) <= ENTRIES)
      else $error("fill count above table size");

   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_FIN))
      else $error("response raised outside the finish step");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != ST_IDLE)
      else $error("request transfer did not start a search");
`endif

endmodule

`default_nettype wire

>>> tb/sv/tb_tlb_fifo_lru_replacement.sv
// ----------------------------------------------------------------------------
// tb_tlb_fifo_lru_replacement
// Self-checking bench for the fully associative translation buffer.
// Lookups and inserts go in on the req_ channel with random gaps. Each one is
// run through a local copy of the table and its replacement policy when it is
// accepted. Responses on rsp_ are checked in order against those predictions
// under random and long stalls. Mode and entry limit are rewritten between
// phases, once the table has gone quiet.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_tlb_fifo_lru_replacement;
   timeunit 1ns;
   timeprecision 1ps;

   import tlbfl_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int MAX_GAP      = 6;
   localparam int DRAIN_CYCLES = ENTRIES + 4;
   localparam int KEY_HISTORY  = 24;
   localparam int PHASES       = 8;
   localparam int PHASE_ITEMS  = 64;

   // indexes with no register behind them
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = 2'd3;

   // limits change between phases, 0 and values above ENTRIES among them
   localparam logic PHASE_MODE [PHASES] = '{
      MODE_FIFO, MODE_LRU, MODE_LRU, MODE_FIFO, MODE_LRU, MODE_FIFO, MODE_LRU, MODE_LRU
   };
   localparam logic [CSR_DATA_W-1:0] PHASE_LIMIT [PHASES] = '{
      5'd6, 5'd8, 5'd1, 5'd0, 5'd12, 5'd31, 5'd17, 5'd16
   };

   typedef struct packed {
      logic               hit;
      logic [FRAME_W-1:0] frame;
   } xlat_type;

   typedef struct packed {
      logic [PAGE_W-1:0] page;
      logic [PID_W-1:0]  pid;
   } key_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic                  req_command;
   logic [PAGE_W-1:0]     req_page_number;
   logic [PID_W-1:0]      req_process_id;
   logic [FRAME_W-1:0]    req_frame_in;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic                  rsp_hit;
   logic [FRAME_W-1:0]    rsp_frame_out;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   tlb_fifo_lru_replacement dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_command     (req_command),
      .req_page_number (req_page_number),
      .req_process_id  (req_process_id),
      .req_frame_in    (req_frame_in),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_hit         (rsp_hit),
      .rsp_frame_out   (rsp_frame_out),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   // local copy of the table
   logic                  tbl_valid [ENTRIES];
   logic [PAGE_W-1:0]     tbl_page  [ENTRIES];
   logic [PID_W-1:0]      tbl_pid   [ENTRIES];
   logic [FRAME_W-1:0]    tbl_frame [ENTRIES];
   logic [STAMP_W-1:0]    tbl_ins   [ENTRIES];
   logic [STAMP_W-1:0]    tbl_use   [ENTRIES];
   int                    tbl_fill;
   logic [STAMP_W-1:0]    tbl_stamp;
   logic                  tbl_mode;
   logic [CSR_DATA_W-1:0] tbl_limit;

   xlat_type pending_xlat [$];
   key_type  recent_keys [$];
   int    mismatches = 0;
   int    cycles = 0;
   int    rsp_hold = 0;
   logic  quiet = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("tb_tlb_fifo_lru_replacement: FAIL");
      $finish;
   end

   function automatic logic [STAMP_W-1:0] entry_age(int i);
      return tbl_stamp - tbl_ins[i];
   endfunction

   function automatic int victim_slot();
      int best = -1;
      for (int i = 0; i < ENTRIES; i++) begin
         if (!tbl_valid[i])
            continue;
         if (best < 0)
            best = i;
         else if (tbl_mode == MODE_LRU) begin
            if (tbl_use[i] < tbl_use[best] ||
                (tbl_use[i] == tbl_use[best] && entry_age(i) > entry_age(best)))
               best = i;
         end else if (entry_age(i) > entry_age(best)) begin
            best = i;
         end
      end
      return best;
   endfunction

   // Applies one request to the local table and returns its response.
   function automatic xlat_type expected_translation(logic cmd, logic [PAGE_W-1:0] page,
                                                     logic [PID_W-1:0] pid,
                                                     logic [FRAME_W-1:0] frame);
      xlat_type r;
      int    slot;
      int    lim;
      int    free_idx;
      r = '0;
      slot = -1;
      if (cmd == CMD_LOOKUP) begin
         // several matches: oldest insert wins, ties to the lowest slot
         for (int i = 0; i < ENTRIES; i++)
            if (tbl_valid[i] && tbl_page[i] == page && tbl_pid[i] == pid &&
                (slot < 0 || entry_age(i) > entry_age(slot)))
               slot = i;
         if (slot >= 0) begin
            r.hit = 1'b1;
            r.frame = tbl_frame[slot];
            if (tbl_mode == MODE_LRU) begin
               tbl_use[slot] = tbl_stamp;
               tbl_stamp = tbl_stamp + 1'b1;
            end
         end
         return r;
      end
      lim = int'(tbl_limit);
      if (lim < 1)
         lim = 1;
      if (lim > ENTRIES)
         lim = ENTRIES;
      free_idx = -1;
      for (int i = ENTRIES - 1; i >= 0; i--)
         if (!tbl_valid[i])
            free_idx = i;
      if (tbl_fill < lim) begin
         slot = free_idx;
         if (slot < 0)
            slot = victim_slot();
         else
            tbl_fill++;
      end else begin
         slot = victim_slot();
         if (slot < 0) begin
            slot = free_idx;
            if (slot >= 0)
               tbl_fill++;
         end
      end
      if (slot >= 0) begin
         tbl_valid[slot] = 1'b1;
         tbl_page[slot]  = page;
         tbl_pid[slot]   = pid;
         tbl_frame[slot] = frame;
         tbl_ins[slot]   = tbl_stamp;
         tbl_use[slot]   = tbl_stamp;
         tbl_stamp = tbl_stamp + 1'b1;
      end
      return r;
   endfunction

   function automatic void note_mismatch(string what, logic [31:0] want, logic [31:0] got);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t: %s mismatch, expected %0h got %0h", $time, what, want, got);
   endfunction

   // response side: per-transfer random gap, plus a long hold when asked
   initial begin : rsp_stall_gen
      int gap;
      gap = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid === 1'b1 && !rsp_stall)
            gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
         if (rsp_hold != 0) begin
            rsp_hold--;
            rsp_stall <= 1'b1;
         end else if (gap != 0) begin
            gap--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      xlat_type want;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (pending_xlat.size() == 0) begin
            note_mismatch("unexpected response", '0, 32'({rsp_hit, rsp_frame_out}));
         end else begin
            want = pending_xlat.pop_front();
            if (rsp_hit !== want.hit)
               note_mismatch("hit", 32'(want.hit), 32'(rsp_hit));
            if (rsp_frame_out !== want.frame)
               note_mismatch("frame_out", 32'(want.frame), 32'(rsp_frame_out));
         end
      end
   end

   task automatic send_item(logic cmd, logic [PAGE_W-1:0] page, logic [PID_W-1:0] pid,
                            logic [FRAME_W-1:0] frame);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_command     <= cmd;
      req_page_number <= page;
      req_process_id  <= pid;
      req_frame_in    <= frame;
      do @(posedge clock); while (req_stall);
      pending_xlat.push_back(expected_translation(cmd, page, pid, frame));
      if (cmd == CMD_INSERT) begin
         recent_keys.push_back('{page: page, pid: pid});
         if (recent_keys.size() > KEY_HISTORY)
            void'(recent_keys.pop_front());
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_xlat.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      drain();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_MODE:  tbl_mode = data[0];
         CSR_LIMIT: tbl_limit = data;
         default: ;
      endcase
   endtask

   // Inserts, and lookups mostly of recent keys, some near misses, some noise.
   task automatic random_items(int count);
      key_type k;
      int   roll;
      repeat (count) begin
         roll = $urandom_range(0, 99);
         k.page = ($urandom_range(0, 1) != 0) ? PAGE_W'($urandom()) :
                                                PAGE_W'($urandom_range(0, 63));
         k.pid  = ($urandom_range(0, 1) != 0) ? PID_W'($urandom_range(0, 16'hFFFF)) :
                                                PID_W'($urandom_range(0, 3));
         if (roll < 45) begin
            // duplicate keys now and then
            if (recent_keys.size() != 0 && $urandom_range(0, 99) < 20)
               k = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
            send_item(CMD_INSERT, k.page, k.pid, FRAME_W'($urandom_range(0, 16'hFFFF)));
         end else begin
            if (recent_keys.size() != 0 && roll < 93) begin
               k = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
               if (roll >= 85)
                  k ^= key_type'(1) << $urandom_range(0, PAGE_W + PID_W - 1);
            end
            send_item(CMD_LOOKUP, k.page, k.pid, FRAME_W'($urandom_range(0, 16'hFFFF)));
         end
      end
   endtask

   task automatic test_reset_defaults();
      send_item(CMD_LOOKUP, '0, '0, '1);
      send_item(CMD_INSERT, '0, '0, '1);
      send_item(CMD_INSERT, '1, '1, '0);
      send_item(CMD_LOOKUP, '0, '0, '0);
      send_item(CMD_LOOKUP, '1, '1, '1);
      send_item(CMD_LOOKUP, '1, '0, '0);
   endtask

   task automatic test_duplicate_keys();
      send_item(CMD_INSERT, 32'h0000_1234, 16'd7, 16'hA5A5);
      send_item(CMD_INSERT, 32'h0000_1234, 16'd7, 16'h5A5A);
      send_item(CMD_LOOKUP, 32'h0000_1234, 16'd7, '0);
   endtask

   task automatic test_fifo_victim();
      csr_write(CSR_LIMIT, 5'd5);
      send_item(CMD_INSERT, 32'd100, 16'd1, 16'h0100);
      send_item(CMD_INSERT, 32'd101, 16'd1, 16'h0101);
      send_item(CMD_LOOKUP, '0, '0, '0);
      send_item(CMD_LOOKUP, 32'd101, 16'd1, '0);
      // oldest entry (the all-ones key) goes next; the older duplicate still answers
      send_item(CMD_INSERT, 32'd102, 16'd1, 16'h0102);
      send_item(CMD_LOOKUP, 32'h0000_1234, 16'd7, '0);
   endtask

   task automatic test_lru_victim();
      // switch with entries held: existing stamps are reused
      csr_write(CSR_MODE, CSR_DATA_W'(MODE_LRU));
      send_item(CMD_LOOKUP, '1, '1, '0);
      send_item(CMD_INSERT, 32'd200, 16'd2, 16'h0200);
      send_item(CMD_LOOKUP, '1, '1, '0);
   endtask

   task automatic test_limit_clamp();
      csr_write(CSR_LIMIT, 5'd0);
      send_item(CMD_INSERT, 32'd300, 16'd3, 16'h0300);
      csr_write(CSR_SPARE_A, 5'h1F);
      csr_write(CSR_SPARE_B, 5'h00);
      send_item(CMD_LOOKUP, 32'd300, 16'd3, '0);
      // only bit 0 of the mode write counts
      csr_write(CSR_MODE, 5'h1E);
      send_item(CMD_INSERT, 32'd301, 16'd3, 16'h0301);
   endtask

   task automatic test_random_phases();
      for (int p = 0; p < PHASES; p++) begin
         csr_write(CSR_MODE, CSR_DATA_W'(PHASE_MODE[p]));
         csr_write(CSR_LIMIT, PHASE_LIMIT[p]);
         quiet = (p % 3 == 2);
         random_items(PHASE_ITEMS);
      end
      quiet = 1'b0;
   endtask

   task automatic test_backpressure();
      // long hold on the response side while requests keep coming
      quiet = 1'b1;
      rsp_hold = 240;
      random_items(12);
      quiet = 1'b0;
   endtask

   initial begin
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_command     <= CMD_LOOKUP;
      req_page_number <= '0;
      req_process_id  <= '0;
      req_frame_in    <= '0;
      csr_valid       <= 1'b0;
      csr_index       <= CSR_MODE;
      csr_wdata       <= '0;
      for (int i = 0; i < ENTRIES; i++)
         tbl_valid[i] = 1'b0;
      tbl_fill  = 0;
      tbl_stamp = '0;
      tbl_mode  = MODE_FIFO;
      tbl_limit = LIMIT_RESET;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_duplicate_keys();
      test_fifo_victim();
      test_lru_victim();
      test_limit_clamp();
      test_random_phases();
      test_backpressure();
      drain();

      if (mismatches == 0)
         $display("tb_tlb_fifo_lru_replacement: PASS");
      else
         $display("tb_tlb_fifo_lru_replacement: FAIL");
      $finish;
   end

endmodule

`default_nettype wire
